@@ hdl/itpc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package itpc_pkg;

  localparam int unsigned REG_W  = 8;
  localparam int unsigned LINE_W = 16;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned LVL_W  = 2;
  localparam int unsigned OP_W   = 3;
  localparam int unsigned TAG_W  = 3;
  localparam int unsigned KIND_W = 3;

  localparam int unsigned NUM_REGS_DEF  = 256;
  localparam int unsigned CTX_DEPTH_DEF = 64;

  // generation mark kept beside each register's level; a start bumps it
  localparam int unsigned EPOCH_W = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};

  localparam int unsigned MAX_RES = 3;
  localparam int unsigned RES_W   = 2;
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QCW     = $clog2(QDEPTH + 1);
  localparam int unsigned QPW     = $clog2(QDEPTH);

  localparam logic [OP_W-1:0] OP_OTHER  = 3'd0;
  localparam logic [OP_W-1:0] OP_LABEL  = 3'd1;
  localparam logic [OP_W-1:0] OP_BRANCH = 3'd2;
  localparam logic [OP_W-1:0] OP_CALL   = 3'd3;
  localparam logic [OP_W-1:0] OP_LOAD   = 3'd4;
  localparam logic [OP_W-1:0] OP_STORE  = 3'd5;
  localparam logic [OP_W-1:0] OP_CMP    = 3'd6;
  localparam logic [OP_W-1:0] OP_PROP   = 3'd7;

  localparam logic [TAG_W-1:0] TAG_NONE         = 3'd0;
  localparam logic [TAG_W-1:0] TAG_UNTRUSTED    = 3'd1;
  localparam logic [TAG_W-1:0] TAG_STORAGE      = 3'd2;
  localparam logic [TAG_W-1:0] TAG_SELFDESTRUCT = 3'd3;
  localparam logic [TAG_W-1:0] TAG_OTHER        = 3'd4;

  localparam logic [LVL_W-1:0] LVL_SAFE    = 2'd0;
  localparam logic [LVL_W-1:0] LVL_CHECKED = 2'd1;
  localparam logic [LVL_W-1:0] LVL_TAINTED = 2'd2;

  localparam logic [KIND_W-1:0] KIND_SLOT         = 3'd0;
  localparam logic [KIND_W-1:0] KIND_VALUE        = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CHECKED      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CALL         = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SELFDESTRUCT = 3'd4;

  typedef struct packed {
    logic              start_of_function;
    logic [OP_W-1:0]   opcode;
    logic [TAG_W-1:0]  tag;
    logic              dst_valid;
    logic [REG_W-1:0]  dst_reg;
    logic              src1_valid;
    logic [REG_W-1:0]  src1_reg;
    logic              src2_valid;
    logic [REG_W-1:0]  src2_reg;
    logic              target_valid;
    logic [REG_W-1:0]  target_reg;
    logic [LINE_W-1:0] line_number;
  } node_t;

  typedef struct packed {
    logic [KIND_W-1:0] sink_kind;
    logic              implicit_flow;
    logic [REG_W-1:0]  operand_reg;
    logic [LVL_W-1:0]  taint_level;
    logic [LINE_W-1:0] sink_line;
    logic              origin_known;
    logic [LINE_W-1:0] origin_line;
    logic [CNT_W-1:0]  violation_count;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [LVL_W-1:0]   level;
    logic [LINE_W-1:0]  line;
  } store_word_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [REG_W-1:0]  opreg;
    logic [LVL_W-1:0]  level;
    logic              known;
    logic [LINE_W-1:0] oline;
    logic [CNT_W-1:0]  count;
  } rec_t;

  typedef struct packed {
    logic [RES_W-1:0]  k;
    logic              implicit_flow;
    logic [LINE_W-1:0] sink_line;
    rec_t [MAX_RES-1:0] rec;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_push_t;

  function automatic logic [LVL_W-1:0] lvl_max(logic [LVL_W-1:0] a, logic [LVL_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a, logic [RES_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + (CNT_W + 1)'(b);
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ hdl/itpc_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface itpc_node_if;
  logic            valid;
  logic            ready;
  itpc_pkg::node_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface itpc_viol_if;
  logic              valid;
  logic              ready;
  itpc_pkg::result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ hdl/itpc_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module itpc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word when the same address is written
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hdl/itpc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module itpc_front #(
  parameter int unsigned NUM_REGS  = 256,
  parameter int unsigned CTX_DEPTH = 64
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  itpc_node_if.sink                    nodes,
  input  wire logic [itpc_pkg::QCW-1:0] q_level,
  output itpc_pkg::q_push_t            push
);
  import itpc_pkg::*;

  localparam int unsigned AW = $clog2(NUM_REGS);
  localparam int unsigned CW = (CTX_DEPTH > 1) ? $clog2(CTX_DEPTH) : 1;
  localparam int unsigned DW = $clog2(CTX_DEPTH + 1);
  localparam int unsigned SW = $bits(store_word_t);
  localparam int unsigned NP = 4;
  localparam int unsigned P_DST  = 0;
  localparam int unsigned P_SRC1 = 1;
  localparam int unsigned P_SRC2 = 2;
  localparam int unsigned P_TGT  = 3;

  function automatic logic in_rng(logic [REG_W-1:0] r);
    return 32'(r) < NUM_REGS;
  endfunction

  // stage 1 registers
  logic               s1_valid;
  node_t              s1_node;
  logic [EPOCH_W-1:0] s1_epoch;
  logic [EPOCH_W-1:0] epoch;
  logic [EPOCH_W-1:0] epoch_item;

  logic               sweeping;
  logic [AW-1:0]      sweep_addr;

  // last write, forwarded to the item whose read shared its edge
  logic               lw_valid;
  logic [AW-1:0]      lw_addr;
  store_word_t        lw_word;

  logic [DW-1:0]      depth;
  logic [DW-1:0]      depth_eff;
  logic [DW-1:0]      depth1;
  logic [DW-1:0]      depth_next;
  logic [LVL_W-1:0]   ctx_top;
  logic [LVL_W-1:0]   top1;
  logic [LVL_W-1:0]   below;
  logic [LVL_W-1:0]   below_reg;
  logic               below_fwd;
  logic [LVL_W-1:0]   ctx_rdata;
  logic [LVL_W-1:0]   ctx;
  logic               push_wr;
  logic               ctx_we;

  logic [CNT_W-1:0]   vcount;
  logic [CNT_W-1:0]   base;
  logic [CNT_W-1:0]   cnt_next;

  logic               acc;
  logic               wrap_hold;
  logic               wrap_start;
  logic               room;

  logic [REG_W-1:0]   in_reg [NP];
  logic [REG_W-1:0]   s1_reg [NP];
  logic               s1_v   [NP];
  logic [SW-1:0]      rd_raw [NP];
  store_word_t        fw_word [NP];
  logic [LVL_W-1:0]   lvl    [NP];

  logic               is_src;
  logic               done;
  logic [LVL_W-1:0]   lvl_w;
  logic               s1_wr;
  store_word_t        wr_word;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [SW-1:0]      ram_wdata;

  logic               cand_v [MAX_RES];
  rec_t               cand   [MAX_RES];
  rec_t [MAX_RES-1:0] recs;
  logic [RES_W-1:0]   k;
  logic [LVL_W-1:0]   sl;
  logic [LVL_W-1:0]   vl;
  logic [LVL_W-1:0]   tl;
  logic [LVL_W-1:0]   bl;

  // ---------------- accept side
  assign wrap_hold  = nodes.valid && nodes.payload.start_of_function && (epoch == EPOCH_MAX);
  assign wrap_start = !sweeping && wrap_hold && !s1_valid;
  assign room       = (32'(q_level) + 32'(s1_valid)) < QDEPTH;
  assign nodes.ready = !sweeping && !wrap_hold && room;
  assign acc        = nodes.valid && nodes.ready;
  assign epoch_item = nodes.payload.start_of_function ? epoch + 1'b1 : epoch;

  assign in_reg[P_DST]  = nodes.payload.dst_reg;
  assign in_reg[P_SRC1] = nodes.payload.src1_reg;
  assign in_reg[P_SRC2] = nodes.payload.src2_reg;
  assign in_reg[P_TGT]  = nodes.payload.target_reg;

  assign s1_reg[P_DST]  = s1_node.dst_reg;
  assign s1_reg[P_SRC1] = s1_node.src1_reg;
  assign s1_reg[P_SRC2] = s1_node.src2_reg;
  assign s1_reg[P_TGT]  = s1_node.target_reg;
  assign s1_v[P_DST]    = s1_node.dst_valid;
  assign s1_v[P_SRC1]   = s1_node.src1_valid;
  assign s1_v[P_SRC2]   = s1_node.src2_valid;
  assign s1_v[P_TGT]    = s1_node.target_valid;

  // one copy of the register store per operand read
  for (genvar p = 0; p < NP; p++) begin : g_store
    itpc_ram #(.WIDTH(SW), .DEPTH(NUM_REGS)) u_store (
      .clk   (clk),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (AW'(in_reg[p])),
      .rdata (rd_raw[p])
    );
  end

  always_comb begin
    for (int p = 0; p < NP; p++) begin
      fw_word[p] = (lw_valid && (lw_addr == AW'(s1_reg[p]))) ? lw_word : store_word_t'(rd_raw[p]);
      lvl[p] = (s1_v[p] && in_rng(s1_reg[p]) && (fw_word[p].epoch == s1_epoch))
               ? fw_word[p].level : LVL_SAFE;
    end
  end

  // ---------------- branch context stack: top in a register, rest in RAM
  itpc_ram #(.WIDTH(LVL_W), .DEPTH(CTX_DEPTH)) u_ctx (
    .clk   (clk),
    .we    (ctx_we),
    .waddr (CW'(depth_eff - DW'(1))),
    .wdata (ctx_top),
    .raddr (CW'(depth_next - DW'(2))),
    .rdata (ctx_rdata)
  );

  assign below = below_fwd ? below_reg : ctx_rdata;

  always_comb begin
    depth_eff = s1_node.start_of_function ? '0 : depth;
    depth1    = depth_eff;
    top1      = ctx_top;
    push_wr   = 1'b0;
    if (s1_node.opcode == OP_LABEL && depth_eff != '0) begin
      depth1 = depth_eff - DW'(1);
      top1   = below;
    end
    if (s1_node.opcode == OP_BRANCH && lvl[P_SRC1] != LVL_SAFE
        && depth_eff < DW'(CTX_DEPTH)) begin
      push_wr = (depth_eff != '0);
      top1    = lvl[P_SRC1];
      depth1  = depth_eff + DW'(1);
    end
    ctx        = (depth1 != '0) ? top1 : LVL_SAFE;
    depth_next = s1_valid ? depth1 : depth;
    ctx_we     = s1_valid && push_wr;
  end

  // ---------------- taint rules
  always_comb begin
    is_src = s1_node.dst_valid
             && ((s1_node.opcode == OP_CALL && s1_node.tag == TAG_UNTRUSTED)
              || (s1_node.opcode == OP_LOAD && s1_node.tag == TAG_NONE));
    lvl_w = LVL_SAFE;
    done  = 1'b0;
    if (is_src) begin
      lvl_w = LVL_TAINTED;
      done  = 1'b1;
    end else if (s1_node.opcode == OP_CMP && s1_node.dst_valid) begin
      if ((lvl[P_SRC1] == LVL_TAINTED && lvl[P_SRC2] == LVL_SAFE)
          || (lvl[P_SRC2] == LVL_TAINTED && lvl[P_SRC1] == LVL_SAFE)) begin
        lvl_w = LVL_CHECKED;
      end else begin
        lvl_w = lvl_max(lvl[P_SRC1], lvl[P_SRC2]);
      end
      // both safe: no update, the node falls through to the sink checks
      done = (lvl[P_SRC1] != LVL_SAFE) || (lvl[P_SRC2] != LVL_SAFE);
    end else if (s1_node.opcode == OP_PROP && s1_node.dst_valid) begin
      lvl_w = lvl_max(lvl[P_SRC1], lvl[P_SRC2]);
      done  = 1'b1;
    end else if (s1_node.opcode == OP_LOAD && s1_node.dst_valid) begin
      lvl_w = (lvl[P_SRC1] != LVL_SAFE) ? LVL_TAINTED : LVL_SAFE;
      done  = 1'b1;
    end
    s1_wr = s1_valid && s1_node.dst_valid && in_rng(s1_node.dst_reg) && (lvl_w > lvl[P_DST]);
    wr_word.epoch = s1_epoch;
    wr_word.level = lvl_w;
    wr_word.line  = s1_node.line_number;
  end

  assign ram_we    = sweeping || s1_wr;
  assign ram_waddr = sweeping ? sweep_addr : AW'(s1_node.dst_reg);
  assign ram_wdata = sweeping ? '0 : wr_word;

  // ---------------- sink checks
  function automatic rec_t mk_rec(logic [KIND_W-1:0] kind, logic v, logic [REG_W-1:0] r,
                                  logic [LVL_W-1:0] stored, logic [LINE_W-1:0] line,
                                  logic [LVL_W-1:0] level);
    rec_t rr;
    rr.kind  = kind;
    rr.opreg = v ? r : '0;
    rr.level = level;
    rr.known = (stored != LVL_SAFE);
    rr.oline = (stored != LVL_SAFE) ? line : '0;
    rr.count = '0;
    return rr;
  endfunction

  always_comb begin
    for (int i = 0; i < MAX_RES; i++) begin
      cand_v[i] = 1'b0;
      cand[i]   = '0;
    end
    sl = lvl_max(ctx, lvl[P_DST]);
    vl = lvl_max(ctx, lvl[P_SRC1]);
    tl = lvl_max(ctx, lvl[P_TGT]);
    bl = vl;
    if (!done) begin
      if (s1_node.opcode == OP_STORE && s1_node.tag == TAG_STORAGE) begin
        cand_v[0] = (sl == LVL_TAINTED);
        cand[0]   = mk_rec(KIND_SLOT, s1_node.dst_valid, s1_node.dst_reg, lvl[P_DST],
                           fw_word[P_DST].line, LVL_TAINTED);
        cand_v[1] = (vl == LVL_TAINTED);
        cand[1]   = mk_rec(KIND_VALUE, s1_node.src1_valid, s1_node.src1_reg, lvl[P_SRC1],
                           fw_word[P_SRC1].line, LVL_TAINTED);
        if (sl == LVL_CHECKED) begin
          cand_v[2] = 1'b1;
          cand[2]   = mk_rec(KIND_CHECKED, s1_node.dst_valid, s1_node.dst_reg, lvl[P_DST],
                             fw_word[P_DST].line, LVL_CHECKED);
        end else if (vl == LVL_CHECKED) begin
          cand_v[2] = 1'b1;
          cand[2]   = mk_rec(KIND_CHECKED, s1_node.src1_valid, s1_node.src1_reg, lvl[P_SRC1],
                             fw_word[P_SRC1].line, LVL_CHECKED);
        end
      end else begin
        if (s1_node.opcode == OP_CALL && s1_node.tag == TAG_UNTRUSTED) begin
          cand_v[0] = (tl == LVL_TAINTED);
          cand[0]   = mk_rec(KIND_CALL, s1_node.target_valid, s1_node.target_reg, lvl[P_TGT],
                             fw_word[P_TGT].line, LVL_TAINTED);
        end
        if (s1_node.tag == TAG_SELFDESTRUCT) begin
          cand_v[1] = (bl != LVL_SAFE);
          cand[1]   = mk_rec(KIND_SELFDESTRUCT, s1_node.src1_valid, s1_node.src1_reg,
                             lvl[P_SRC1], fw_word[P_SRC1].line, bl);
        end
      end
    end
  end

  // pack the reported violations in order and number them
  always_comb begin
    base = s1_node.start_of_function ? '0 : vcount;
    recs = '0;
    k    = '0;
    for (int i = 0; i < MAX_RES; i++) begin
      if (cand_v[i]) begin
        recs[k]       = cand[i];
        recs[k].count = sat_add(base, RES_W'(k + RES_W'(1)));
        k             = k + RES_W'(1);
      end
    end
    cnt_next = sat_add(base, k);
  end

  assign push.valid               = s1_valid && (k != '0);
  assign push.entry.k             = k;
  assign push.entry.implicit_flow = (ctx != LVL_SAFE);
  assign push.entry.sink_line     = s1_node.line_number;
  assign push.entry.rec           = recs;

  // ---------------- registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      epoch      <= '0;
      sweeping   <= 1'b1;
      sweep_addr <= '0;
      lw_valid   <= 1'b0;
      depth      <= '0;
      below_fwd  <= 1'b0;
      vcount     <= '0;
    end else begin
      s1_valid  <= acc;
      depth     <= depth_next;
      below_fwd <= ctx_we;
      if (acc) begin
        epoch <= epoch_item;
      end
      if (sweeping) begin
        lw_valid <= 1'b0;
        if (sweep_addr == AW'(NUM_REGS - 1)) begin
          sweeping <= 1'b0;
        end else begin
          sweep_addr <= sweep_addr + 1'b1;
        end
      end else if (wrap_start) begin
        // all levels go back to safe before the mark is reused
        sweeping   <= 1'b1;
        sweep_addr <= '0;
        epoch      <= '0;
      end else if (s1_wr) begin
        lw_valid <= 1'b1;
      end
      if (s1_valid) begin
        vcount <= cnt_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_node  <= nodes.payload;
      s1_epoch <= epoch_item;
    end
    if (s1_wr) begin
      lw_addr <= AW'(s1_node.dst_reg);
      lw_word <= wr_word;
    end
    if (ctx_we) begin
      below_reg <= ctx_top;
    end
    if (s1_valid) begin
      ctx_top <= top1;
    end
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DW'(CTX_DEPTH))
    else $error("context depth beyond stack size");

  a_no_write_in_sweep: assert property (@(posedge clk) disable iff (rst)
    !(sweeping && s1_valid))
    else $error("node in flight during store sweep");

  a_start_epoch: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_node.start_of_function) |-> (s1_epoch != '0))
    else $error("start node carries a reused generation mark");

endmodule

`default_nettype wire

@@ hdl/itpc_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module itpc_queue (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire itpc_pkg::q_push_t        push,
  input  wire logic                     pop,
  output itpc_pkg::entry_t              head,
  output logic                          empty,
  output logic [itpc_pkg::QCW-1:0]      level
);
  import itpc_pkg::*;

  entry_t         slots [QDEPTH];
  logic [QPW-1:0] wr_ptr;
  logic [QPW-1:0] rd_ptr;

  function automatic logic [QPW-1:0] ptr_inc(logic [QPW-1:0] p);
    return (p == QPW'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head  = slots[rd_ptr];
  assign empty = (level == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({push.valid, pop})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.entry;
    end
  end

  a_credit: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> (level != QCW'(QDEPTH)))
    else $error("queue written while full");

endmodule

`default_nettype wire

@@ hdl/itpc_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module itpc_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire itpc_pkg::entry_t head,
  input  wire logic             empty,
  output logic                  pop,
  itpc_viol_if.source           violations
);
  import itpc_pkg::*;

  entry_t           cur;
  logic             cur_valid;
  logic [RES_W-1:0] idx;
  logic             take;
  logic             at_last;
  rec_t             rec;

  assign at_last = (idx == cur.k - RES_W'(1));
  assign take    = violations.valid && violations.ready;
  assign pop     = !empty && (!cur_valid || (take && at_last));
  assign rec     = cur.rec[idx];

  assign violations.valid                   = cur_valid;
  assign violations.payload.sink_kind       = rec.kind;
  assign violations.payload.implicit_flow   = cur.implicit_flow;
  assign violations.payload.operand_reg     = rec.opreg;
  assign violations.payload.taint_level     = rec.level;
  assign violations.payload.sink_line       = cur.sink_line;
  assign violations.payload.origin_known    = rec.known;
  assign violations.payload.origin_line     = rec.oline;
  assign violations.payload.violation_count = rec.count;
  assign violations.payload.last            = at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (take && at_last) begin
      cur_valid <= 1'b0;
    end else if (take) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (cur.k != '0 && idx < cur.k))
    else $error("result index outside the node's result count");

endmodule

`default_nettype wire

@@ hdl/ir_taint_propagation_checker.sv @@
// channel     | dir | handshake     | transaction
// ------------+-----+---------------+-------------------------------------
// nodes       | in  | valid / ready | one IR node
// violations  | out | valid / ready | one violation record, last marks end
//
// One node per cycle while queue credit remains and no sweep runs; a node
// with n violations holds the output for n records. After reset the
// register store is swept, one entry per cycle, with nodes held off; the
// same sweep runs when a function start exhausts the 8-bit generation mark
// (once every 255 starts). A four-entry queue decouples a stalled output
// from the front; the front takes nodes while queue credit remains.
`timescale 1ns / 1ps
`default_nettype none

module ir_taint_propagation_checker #(
  parameter int unsigned NUM_REGS  = itpc_pkg::NUM_REGS_DEF,
  parameter int unsigned CTX_DEPTH = itpc_pkg::CTX_DEPTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  itpc_node_if.sink   nodes,
  itpc_viol_if.source violations
);
  import itpc_pkg::*;

  q_push_t        push;
  entry_t         head;
  logic           empty;
  logic           pop;
  logic [QCW-1:0] q_level;

  itpc_front #(.NUM_REGS(NUM_REGS), .CTX_DEPTH(CTX_DEPTH)) u_front (
    .clk     (clk),
    .rst     (rst),
    .nodes   (nodes),
    .q_level (q_level),
    .push    (push)
  );

  itpc_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .empty (empty),
    .level (q_level)
  );

  itpc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .violations (violations)
  );

endmodule

`default_nettype wire

@@ tb/ir_taint_propagation_checker_test.sv @@
`timescale 1ns / 1ps

module ir_taint_propagation_checker_test;
  import itpc_pkg::*;

  localparam int HOLD_CYCLES = 150;

  logic clk;
  logic rst;

  itpc_node_if node_bus ();
  itpc_viol_if viol_bus ();

  ir_taint_propagation_checker dut (
    .clk        (clk),
    .rst        (rst),
    .nodes      (node_bus),
    .violations (viol_bus)
  );

  // shadow of the block's state
  logic [LVL_W-1:0]  taint_lvl    [NUM_REGS_DEF];
  logic [LINE_W-1:0] taint_origin [NUM_REGS_DEF];
  logic [LVL_W-1:0]  branch_ctx   [CTX_DEPTH_DEF];
  int unsigned       branch_depth;
  logic [CNT_W-1:0]  viol_total;

  node_t   node_backlog [$];
  result_t pending_violations [$];

  int   fail_count;
  bit   send_idle_en;
  bit   recv_idle_en;
  logic hold_start;

  logic [3:0] send_gap;
  logic [3:0] recv_gap;
  int         hold_left;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(20_000_000);
    $display("ir_taint_propagation_checker_test: FAIL");
    $finish;
  end

  function automatic logic [LVL_W-1:0] read_level(logic v, logic [REG_W-1:0] r);
    return v ? taint_lvl[r] : LVL_SAFE;
  endfunction

  function automatic void raise_level_to(logic v, logic [REG_W-1:0] r,
                                         logic [LVL_W-1:0] l, logic [LINE_W-1:0] ln);
    if (v && l > taint_lvl[r]) begin
      taint_lvl[r]    = l;
      taint_origin[r] = ln;
    end
  endfunction

  function automatic result_t record_violation(logic [KIND_W-1:0] kind, logic [LVL_W-1:0] cx,
                                               logic v, logic [REG_W-1:0] r,
                                               logic [LVL_W-1:0] l, logic [LINE_W-1:0] ln);
    result_t          res;
    logic [LVL_W-1:0] held;
    held = read_level(v, r);
    if (viol_total != {CNT_W{1'b1}}) viol_total = viol_total + 1'b1;
    res.sink_kind       = kind;
    res.implicit_flow   = (cx != LVL_SAFE);
    res.operand_reg     = v ? r : '0;
    res.taint_level     = l;
    res.sink_line       = ln;
    res.origin_known    = (held != LVL_SAFE);
    res.origin_line     = (held != LVL_SAFE) ? taint_origin[r] : '0;
    res.violation_count = viol_total;
    res.last            = 1'b0;
    return res;
  endfunction

  task automatic propagate_node(input node_t nd);
    logic [LVL_W-1:0] t1, t2, cx, sl, vl, tl, bl, c;
    result_t          hits [3];
    int               n;
    int               i;
    n = 0;
    if (nd.start_of_function) begin
      for (i = 0; i < NUM_REGS_DEF; i++) taint_lvl[i] = LVL_SAFE;
      branch_depth = 0;
      viol_total   = '0;
    end

    if (nd.opcode == OP_LABEL && branch_depth > 0) branch_depth--;
    if (nd.opcode == OP_BRANCH) begin
      c = read_level(nd.src1_valid, nd.src1_reg);
      if (c != LVL_SAFE && branch_depth < CTX_DEPTH_DEF) begin
        branch_ctx[branch_depth] = c;
        branch_depth++;
      end
    end

    // taint sources win over any sink check
    if (nd.dst_valid && ((nd.opcode == OP_CALL && nd.tag == TAG_UNTRUSTED) ||
                         (nd.opcode == OP_LOAD && nd.tag == TAG_NONE))) begin
      raise_level_to(1'b1, nd.dst_reg, LVL_TAINTED, nd.line_number);
      return;
    end

    t1 = read_level(nd.src1_valid, nd.src1_reg);
    t2 = read_level(nd.src2_valid, nd.src2_reg);

    if (nd.opcode == OP_CMP && nd.dst_valid) begin
      if ((t1 == LVL_TAINTED && t2 == LVL_SAFE) || (t2 == LVL_TAINTED && t1 == LVL_SAFE)) begin
        raise_level_to(1'b1, nd.dst_reg, LVL_CHECKED, nd.line_number);
        return;
      end
      if (t1 != LVL_SAFE || t2 != LVL_SAFE) begin
        raise_level_to(1'b1, nd.dst_reg, (t1 > t2) ? t1 : t2, nd.line_number);
        return;
      end
    end

    if (nd.opcode == OP_PROP && nd.dst_valid) begin
      raise_level_to(1'b1, nd.dst_reg, (t1 > t2) ? t1 : t2, nd.line_number);
      return;
    end

    if (nd.opcode == OP_LOAD && nd.dst_valid) begin
      if (t1 != LVL_SAFE) raise_level_to(1'b1, nd.dst_reg, LVL_TAINTED, nd.line_number);
      return;
    end

    cx = (branch_depth > 0) ? branch_ctx[branch_depth-1] : LVL_SAFE;

    if (nd.opcode == OP_STORE && nd.tag == TAG_STORAGE) begin
      sl = read_level(nd.dst_valid, nd.dst_reg);
      vl = t1;
      if (cx > sl) sl = cx;
      if (cx > vl) vl = cx;
      if (sl == LVL_TAINTED) begin
        hits[n] = record_violation(KIND_SLOT, cx, nd.dst_valid, nd.dst_reg, LVL_TAINTED,
                                   nd.line_number);
        n++;
      end
      if (vl == LVL_TAINTED) begin
        hits[n] = record_violation(KIND_VALUE, cx, nd.src1_valid, nd.src1_reg, LVL_TAINTED,
                                   nd.line_number);
        n++;
      end
      // checked report names the slot first, the value otherwise
      if (sl == LVL_CHECKED) begin
        hits[n] = record_violation(KIND_CHECKED, cx, nd.dst_valid, nd.dst_reg, LVL_CHECKED,
                                   nd.line_number);
        n++;
      end else if (vl == LVL_CHECKED) begin
        hits[n] = record_violation(KIND_CHECKED, cx, nd.src1_valid, nd.src1_reg, LVL_CHECKED,
                                   nd.line_number);
        n++;
      end
    end else begin
      if (nd.opcode == OP_CALL && nd.tag == TAG_UNTRUSTED) begin
        tl = read_level(nd.target_valid, nd.target_reg);
        if (cx > tl) tl = cx;
        if (tl == LVL_TAINTED) begin
          hits[n] = record_violation(KIND_CALL, cx, nd.target_valid, nd.target_reg, LVL_TAINTED,
                                     nd.line_number);
          n++;
        end
      end
      if (nd.tag == TAG_SELFDESTRUCT) begin
        bl = t1;
        if (cx > bl) bl = cx;
        if (bl != LVL_SAFE) begin
          hits[n] = record_violation(KIND_SELFDESTRUCT, cx, nd.src1_valid, nd.src1_reg, bl,
                                     nd.line_number);
          n++;
        end
      end
    end

    for (i = 0; i < n; i++) begin
      if (i == n - 1) hits[i].last = 1'b1;
      pending_violations.push_back(hits[i]);
    end
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_violation(input result_t got);
    result_t want;
    if (pending_violations.size() == 0) begin
      $display("%0t: unexpected violation, expected none, actual %p", $time, got);
      fail_count++;
    end else begin
      want = pending_violations.pop_front();
      compare_field("sink_kind", 16'(want.sink_kind), 16'(got.sink_kind));
      compare_field("implicit_flow", 16'(want.implicit_flow), 16'(got.implicit_flow));
      compare_field("operand_reg", 16'(want.operand_reg), 16'(got.operand_reg));
      compare_field("taint_level", 16'(want.taint_level), 16'(got.taint_level));
      compare_field("sink_line", want.sink_line, got.sink_line);
      compare_field("origin_known", 16'(want.origin_known), 16'(got.origin_known));
      compare_field("origin_line", want.origin_line, got.origin_line);
      compare_field("violation_count", want.violation_count, got.violation_count);
      compare_field("last", 16'(want.last), 16'(got.last));
    end
  endtask

  always @(posedge clk) begin : drive
    logic  nxt_valid;
    node_t nxt;
    if (rst) begin
      node_bus.valid   <= 1'b0;
      node_bus.payload <= '0;
      send_gap         <= '0;
    end else begin
      nxt_valid = node_bus.valid;
      nxt       = node_bus.payload;
      if (node_bus.valid && node_bus.ready) begin
        propagate_node(node_bus.payload);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (send_gap != 0)
          send_gap <= send_gap - 1'b1;
        else if (node_backlog.size() != 0) begin
          if (send_idle_en && $urandom_range(0, 7) == 0)
            send_gap <= 4'($urandom_range(0, 14));
          else begin
            nxt       = node_backlog.pop_front();
            nxt_valid = 1'b1;
          end
        end
      end
      node_bus.valid   <= nxt_valid;
      node_bus.payload <= nxt;
    end
  end

  always @(posedge clk) begin : watch
    if (rst) begin
      viol_bus.ready <= 1'b0;
      recv_gap       <= '0;
      hold_left      <= 0;
    end else begin
      if (viol_bus.valid && viol_bus.ready) check_violation(viol_bus.payload);
      if (hold_start) begin
        hold_left      <= HOLD_CYCLES;
        viol_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left      <= hold_left - 1;
        viol_bus.ready <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap       <= recv_gap - 1'b1;
        viol_bus.ready <= 1'b0;
      end else if (recv_idle_en && $urandom_range(0, 7) == 0) begin
        recv_gap       <= 4'($urandom_range(0, 14));
        viol_bus.ready <= 1'b0;
      end else
        viol_bus.ready <= 1'b1;
    end
  end

  // negative register index means the operand is absent
  task automatic add_node(input int st, input logic [OP_W-1:0] op,
                          input logic [TAG_W-1:0] tg, input int dst, input int s1,
                          input int s2, input int tgt, input int ln);
    node_t nd;
    nd.start_of_function = (st != 0);
    nd.opcode            = op;
    nd.tag               = tg;
    nd.dst_valid         = (dst >= 0);
    nd.dst_reg           = (dst >= 0) ? REG_W'(dst) : '0;
    nd.src1_valid        = (s1 >= 0);
    nd.src1_reg          = (s1 >= 0) ? REG_W'(s1) : '0;
    nd.src2_valid        = (s2 >= 0);
    nd.src2_reg          = (s2 >= 0) ? REG_W'(s2) : '0;
    nd.target_valid      = (tgt >= 0);
    nd.target_reg        = (tgt >= 0) ? REG_W'(tgt) : '0;
    nd.line_number       = LINE_W'(ln);
    node_backlog.push_back(nd);
  endtask

  // mostly a small pool so taint builds up on registers that get reused
  function automatic logic [REG_W-1:0] pick_reg();
    if ($urandom_range(0, 3) == 0) return REG_W'($urandom_range(0, 255));
    return REG_W'($urandom_range(0, 7));
  endfunction

  function automatic node_t random_node(logic st);
    node_t nd;
    int    pick;
    pick                 = $urandom_range(0, 19);
    nd.start_of_function = st;
    nd.opcode            = OP_OTHER;
    nd.tag               = TAG_W'($urandom_range(0, 4));
    nd.dst_valid         = ($urandom_range(0, 9) != 0);
    nd.dst_reg           = pick_reg();
    nd.src1_valid        = ($urandom_range(0, 9) != 0);
    nd.src1_reg          = pick_reg();
    nd.src2_valid        = ($urandom_range(0, 9) != 0);
    nd.src2_reg          = pick_reg();
    nd.target_valid      = ($urandom_range(0, 9) != 0);
    nd.target_reg        = pick_reg();
    nd.line_number       = LINE_W'($urandom_range(0, 65535));
    if (pick < 4) begin
      if ($urandom_range(0, 1) != 0) begin
        nd.opcode = OP_CALL;
        nd.tag    = TAG_UNTRUSTED;
      end else begin
        nd.opcode = OP_LOAD;
        nd.tag    = ($urandom_range(0, 9) < 7) ? TAG_NONE : TAG_OTHER;
      end
    end else if (pick < 7)
      nd.opcode = OP_PROP;
    else if (pick < 9)
      nd.opcode = OP_CMP;
    else if (pick < 11)
      nd.opcode = OP_BRANCH;
    else if (pick < 13)
      nd.opcode = OP_LABEL;
    else if (pick < 16) begin
      nd.opcode = OP_STORE;
      if ($urandom_range(0, 4) != 0) nd.tag = TAG_STORAGE;
    end else if (pick < 18) begin
      nd.opcode = OP_CALL;
      nd.tag    = TAG_UNTRUSTED;
      if ($urandom_range(0, 9) < 7) nd.dst_valid = 1'b0;
    end else if (pick < 19) begin
      nd.opcode = OP_W'($urandom_range(0, 7));
      nd.tag    = TAG_SELFDESTRUCT;
    end else
      nd.opcode = OP_W'($urandom_range(0, 7));
    return nd;
  endfunction

  function automatic node_t noise_node();
    node_t nd;
    nd                   = node_t'($bits(node_t)'({$urandom, $urandom}));
    nd.start_of_function = ($urandom_range(0, 7) == 0);
    nd.tag               = TAG_W'($urandom_range(0, 4));
    return nd;
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (node_backlog.size() != 0 || node_bus.valid || pending_violations.size() != 0);
  endtask

  initial begin : stimulus
    int made;
    int len;
    int sel;
    int i;
    rst              = 1'b1;
    hold_start       = 1'b0;
    send_idle_en     = 1'b1;
    recv_idle_en     = 1'b1;
    fail_count       = 0;
    branch_depth     = 0;
    viol_total       = '0;
    for (i = 0; i < NUM_REGS_DEF; i++) begin
      taint_lvl[i]    = LVL_SAFE;
      taint_origin[i] = '0;
    end
    for (i = 0; i < CTX_DEPTH_DEF; i++) branch_ctx[i] = LVL_SAFE;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: sources, sanitising, propagation, each sink and its corner cases
    add_node(1, OP_CALL,   TAG_UNTRUSTED,    1,  -1, -1, 255, 100);
    add_node(0, OP_LOAD,   TAG_NONE,         2,  -1, -1, -1,  65535);
    add_node(0, OP_CMP,    TAG_NONE,         4,   1,  5, -1,  300);
    add_node(0, OP_PROP,   TAG_OTHER,        6,   4,  0, -1,  0);
    add_node(0, OP_LOAD,   TAG_OTHER,        7,   4, -1, -1,  500);
    add_node(0, OP_CALL,   TAG_UNTRUSTED,    8,  -1, -1,  1,  600);   // source, target ignored
    add_node(0, OP_CALL,   TAG_UNTRUSTED,    -1, -1, -1,  4,  700);   // checked target, silent
    add_node(0, OP_CALL,   TAG_UNTRUSTED,    -1, -1, -1,  7,  800);
    add_node(0, OP_STORE,  TAG_STORAGE,      1,   2, -1, -1,  900);
    add_node(0, OP_STORE,  TAG_STORAGE,      4,   6, -1, -1,  1000);
    add_node(0, OP_STORE,  TAG_STORAGE,      0,   6, -1, -1,  1100);
    add_node(0, OP_STORE,  TAG_STORAGE,      1,   4, -1, -1,  1200);
    add_node(0, OP_OTHER,  TAG_SELFDESTRUCT, -1,  4, -1, -1,  1300);
    add_node(0, OP_LABEL,  TAG_NONE,         -1, -1, -1, -1,  1400);  // empty context stack
    add_node(0, OP_BRANCH, TAG_NONE,         -1,  2, -1, -1,  1500);
    add_node(0, OP_STORE,  TAG_STORAGE,      -1, -1, -1, -1,  1600);
    add_node(0, OP_STORE,  TAG_STORAGE,      255, 255, 255, 255, 65535);
    add_node(0, OP_LABEL,  TAG_NONE,         -1, -1, -1, -1,  1700);
    add_node(0, OP_STORE,  TAG_STORAGE,      255, 0, -1, -1,  1800);
    add_node(0, OP_CMP,    TAG_NONE,         9,   1,  2, -1,  1900);
    add_node(0, OP_CMP,    TAG_NONE,         10,  0,  5, -1,  2000);
    add_node(0, OP_STORE,  TAG_OTHER,        1,   2, -1, -1,  2100);
    add_node(1, OP_STORE,  TAG_STORAGE,      1,   2, -1, -1,  2200);  // cleared first
    add_node(0, OP_PROP,   TAG_SELFDESTRUCT, -1, 255, 0, -1,  2300);
    wait_drained();

    // random: mostly whole functions, some noise and headless fragments
    made = 0;
    while (made < 120) begin
      send_idle_en = ($urandom_range(0, 2) != 0);
      recv_idle_en = ($urandom_range(0, 2) != 0);
      sel = $urandom_range(0, 9);
      len = $urandom_range(6, 16);
      if (sel < 8) begin
        node_backlog.push_back(random_node(1'b1));
        repeat (len - 1) node_backlog.push_back(random_node(1'b0));
      end else if (sel == 8) begin
        len = 5;
        repeat (len) node_backlog.push_back(noise_node());
      end else
        repeat (len) node_backlog.push_back(random_node(1'b0));
      made += len;
      while (node_backlog.size() > 4) @(negedge clk);
    end
    wait_drained();

    // long receiver hold-off while nodes keep coming, so the input stalls
    send_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    @(posedge clk);
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    add_node(1, OP_CALL, TAG_UNTRUSTED, 1, -1, -1, -1, 3000);
    add_node(0, OP_LOAD, TAG_NONE,      2, -1, -1, -1, 3001);
    for (i = 0; i < 20; i++) add_node(0, OP_STORE, TAG_STORAGE, 1, 2, -1, -1, 3100 + i);
    wait_drained();

    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("ir_taint_propagation_checker_test: PASS");
    else
      $display("ir_taint_propagation_checker_test: FAIL");
    $finish;
  end

endmodule

@@ files.f @@
hdl/itpc_pkg.sv
hdl/itpc_if.sv
hdl/itpc_ram.sv
hdl/itpc_front.sv
hdl/itpc_queue.sv
hdl/itpc_back.sv
hdl/ir_taint_propagation_checker.sv
tb/ir_taint_propagation_checker_test.sv
